// ===== design/olid_pkg.sv =====
package olid_pkg;

	localparam int OLID_CAPACITY = 16;
	localparam int VALUE_W       = 32;
	localparam int COUNT_OUT_W   = 5;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_DELETE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		op_t                       op;
		logic signed [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		status_t                  status;
		logic [COUNT_OUT_W-1:0]   entry_count;
	} rsp_t;

endpackage

// ===== design/olid_stream_if.sv =====
interface olid_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== design/ordered_list_insert_delete_top.sv =====
// Bounded ordered list of signed 32-bit values. An insert request puts its value at the head,
// or answers "list full" at CAPACITY entries; a delete request removes the entry nearest the head
// that equals its value, answering "list empty" or "not found" when it cannot. Each request gets
// one response with the status and the entry count after the step (count taken to 5 bits).
// Requests are handled one at a time through a memory with one write port and one registered
// read port, which sets the timing. An insert, a refused request or a delete on an empty list
// goes straight to the response step. A delete first starts the read at the head, then compares
// one entry per cycle from the head. A hit at the head only lowers the count. A hit d places
// below the head then moves the d entries above it down one place, one per cycle, after a step
// that starts the move. A miss ends once the tail entry has been compared. The response is
// loaded into the output register once that register is free. The next request is taken the
// cycle after the response is loaded into the output register, even while that response still
// waits. No clearing pass runs after reset.
module ordered_list_insert_delete_top
	import olid_pkg::*;
#(
	parameter int CAPACITY = OLID_CAPACITY
) (
	input  logic          clk,
	input  logic          arst_n,
	olid_stream_if.sink   req,
	olid_stream_if.source rsp
);

	localparam int IDX_W = $clog2(CAPACITY);

	logic                      mem_we;
	logic [IDX_W-1:0]          mem_waddr;
	logic signed [VALUE_W-1:0] mem_wdata;
	logic [IDX_W-1:0]          mem_raddr;
	logic signed [VALUE_W-1:0] mem_rdata;

	olid_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	olid_mem #(
		.CAPACITY (CAPACITY)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

// ===== design/olid_mem.sv =====
module olid_mem
	import olid_pkg::*;
#(
	parameter int CAPACITY = OLID_CAPACITY,
	localparam int IDX_W   = $clog2(CAPACITY)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [IDX_W-1:0]          waddr,
	input  logic signed [VALUE_W-1:0] wdata,
	input  logic [IDX_W-1:0]          raddr,
	output logic signed [VALUE_W-1:0] rdata
);

	logic signed [VALUE_W-1:0] mem [CAPACITY];
	logic signed [VALUE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// raddr may point past the last entry on a trailing prefetch; that data is never used
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/olid_ctrl.sv =====
module olid_ctrl
	import olid_pkg::*;
#(
	parameter int CAPACITY = OLID_CAPACITY,
	localparam int IDX_W   = $clog2(CAPACITY),
	localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	olid_stream_if.sink               req,
	olid_stream_if.source             rsp,
	output logic                      mem_we,
	output logic [IDX_W-1:0]          mem_waddr,
	output logic signed [VALUE_W-1:0] mem_wdata,
	output logic [IDX_W-1:0]          mem_raddr,
	input  logic signed [VALUE_W-1:0] mem_rdata
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_RESP
	} state_t;

	state_t                    state_q;
	logic [CNT_W-1:0]          count_q;
	logic [IDX_W-1:0]          idx_q;
	logic                      pend_q;
	logic signed [VALUE_W-1:0] key_q;
	status_t                   st_q;
	logic                      rsp_valid_q;
	rsp_t                      rsp_data_q;

	logic             full;
	logic             accept;
	logic             hit;
	logic [IDX_W-1:0] last;

	assign full      = (count_q == CNT_W'(CAPACITY));
	assign last      = IDX_W'(count_q - CNT_W'(1));
	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign hit       = pend_q && (mem_rdata == key_q);

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	// Entries sit tail first: address 0 is the oldest, address count-1 the head
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = IDX_W'(count_q);
		mem_wdata = req.data.value;
		mem_raddr = idx_q;
		unique case (state_q)
			S_IDLE: begin
				mem_we = accept && (req.data.op == OP_INSERT) && !full;
			end
			S_SCAN: begin
				mem_raddr = pend_q ? idx_q - IDX_W'(1) : idx_q;
			end
			S_SHIFT: begin
				if (idx_q != last) begin
					if (!pend_q) begin
						mem_raddr = idx_q + IDX_W'(1);
					end else begin
						mem_we    = 1'b1;
						mem_waddr = idx_q;
						mem_wdata = mem_rdata;
						mem_raddr = idx_q + IDX_W'(2);
					end
				end
			end
			S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			pend_q      <= 1'b0;
			key_q       <= '0;
			st_q        <= ST_DONE;
			rsp_valid_q <= 1'b0;
			rsp_data_q  <= '0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						key_q <= req.data.value;
						unique case (req.data.op)
							OP_INSERT: begin
								if (full) begin
									st_q <= ST_FULL;
								end else begin
									st_q    <= ST_DONE;
									count_q <= count_q + CNT_W'(1);
								end
								state_q <= S_RESP;
							end
							OP_DELETE: begin
								if (count_q == '0) begin
									st_q    <= ST_EMPTY;
									state_q <= S_RESP;
								end else begin
									idx_q   <= last;
									pend_q  <= 1'b0;
									state_q <= S_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SCAN: begin
					// compare the entry read last cycle while fetching the next one down
					priority if (hit) begin
						pend_q  <= 1'b0;
						state_q <= S_SHIFT;
					end else if (pend_q && idx_q == '0) begin
						st_q    <= ST_NOT_FOUND;
						state_q <= S_RESP;
					end else begin
						idx_q  <= mem_raddr;
						pend_q <= 1'b1;
					end
				end
				S_SHIFT: begin
					// move each entry nearer the head down one place over the hole
					priority if (idx_q == last) begin
						count_q <= count_q - CNT_W'(1);
						st_q    <= ST_DONE;
						state_q <= S_RESP;
					end else if (!pend_q) begin
						pend_q <= 1'b1;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_RESP: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q            <= 1'b1;
						rsp_data_q.status      <= st_q;
						rsp_data_q.entry_count <= COUNT_OUT_W'(count_q);
						state_q                <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
